[src/hc_pkg.sv]
// Shared types and constants for the 2x2 byte Hill cipher stream core.
package hc_pkg;

    localparam int ByteW = 8;
    localparam int CfgIdxW = 3;

    typedef logic [ByteW-1:0] t_byte;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_KEY = 2'd1,
        ST_BAD_LEN = 2'd2,
        ST_BAD_PAD = 2'd3
    } t_status;

    typedef enum logic [CfgIdxW-1:0] {
        REG_KEY_A   = 3'd0,
        REG_KEY_B   = 3'd1,
        REG_KEY_C   = 3'd2,
        REG_KEY_D   = 3'd3,
        REG_DECRYPT = 3'd4
    } t_reg_idx;

    // Pad byte values
    localparam t_byte PadOne = 8'd1;
    localparam t_byte PadTwo = 8'd2;

    // Newton steps for the inverse mod 256: seed is good to 3 bits, two steps reach 12
    localparam logic NewtonLast = 1'b1;

    typedef struct packed {
        t_byte key_a;
        t_byte key_b;
        t_byte key_c;
        t_byte key_d;
        logic  decrypt;
    } t_key;

    typedef struct packed {
        t_byte   out_byte;
        logic    out_byte_valid;
        logic    out_last;
        t_status status;
    } t_result;

    typedef struct packed {
        logic  keep;   // 1: add to accumulator, 0: start fresh
        t_byte op_a;
        t_byte op_b;
    } t_mac_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DET0,
        S_DET1,
        S_DETCHK,
        S_INV_T,
        S_INV_X,
        S_INV_U,
        S_MAT,
        S_MATW,
        S_DATA,
        S_MIX0,
        S_MIX1,
        S_MIX2,
        S_MIX3,
        S_MIXW,
        S_END,
        S_EM0,
        S_EM1,
        S_DONE
    } t_state;

endpackage

[src/hc_mac.sv]
// Shared 8x8 multiply-accumulate unit, mod 256, registered result.
module hc_mac
    import hc_pkg::*;
(
    input  logic    i_clk,
    input  t_mac_op i_op,
    output t_byte   o_acc
);

    logic [2*ByteW-1:0] prod;
    t_byte              base;
    t_byte              r_acc;
    t_byte              n_acc;

    always_comb begin
        prod  = i_op.op_a * i_op.op_b;
        base  = i_op.keep ? r_acc : '0;
        n_acc = base + prod[ByteW-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

[src/hc_seq.sv]
// Sequencer: key check, inverse derivation, pair mixing, padding and result issue.
module hc_seq
    import hc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_key    i_key,
    input  logic    i_clear,
    input  logic    i_in_valid,
    input  t_byte   i_data_byte,
    input  logic    i_byte_present,
    input  logic    i_end_of_message,
    output logic    o_busy,
    input  logic    i_slot_free,
    output logic    o_push,
    output t_result o_result,
    output t_mac_op o_mac_op,
    input  t_byte   i_mac_acc
);

    t_state  r_state, n_state;
    t_state  r_ret, n_ret;

    t_byte   r_byte, n_byte;
    logic    r_present, n_present;
    logic    r_eom, n_eom;

    t_byte   r_pending, n_pending;
    logic    r_pend_v, n_pend_v;
    logic [2*ByteW-1:0] r_held, n_held;
    logic    r_held_v, n_held_v;
    logic    r_mat_ready, n_mat_ready;
    t_status r_error, n_error;

    t_byte   r_mat [4];
    logic    mat_we_all, mat_we_one;

    t_byte   r_det, n_det;
    t_byte   r_inv, n_inv;
    logic    r_cnt, n_cnt;
    logic [1:0] r_idx, n_idx;

    t_byte   r_x1, n_x1;
    t_byte   r_x2, n_x2;
    t_byte   r_y1, n_y1;
    logic    r_mix_end, n_mix_end;

    t_result r_em0, n_em0;
    t_result r_em1, n_em1;
    logic    r_two, n_two;

    t_byte   key_sel;
    t_byte   held_hi, held_lo;

    assign held_hi = r_held[2*ByteW-1:ByteW];
    assign held_lo = r_held[ByteW-1:0];

    // Key entry that feeds one inverse-matrix element
    always_comb begin
        case (r_idx)
            2'd0:    key_sel = i_key.key_d;
            2'd1:    key_sel = 8'd0 - i_key.key_b;
            2'd2:    key_sel = 8'd0 - i_key.key_c;
            default: key_sel = i_key.key_a;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend_v    <= 1'b0;
            r_held_v    <= 1'b0;
            r_mat_ready <= 1'b0;
            r_error     <= ST_OK;
            r_pending   <= '0;
            r_held      <= '0;
        end else begin
            r_state     <= n_state;
            r_pend_v    <= n_pend_v;
            r_held_v    <= n_held_v;
            r_mat_ready <= n_mat_ready;
            r_error     <= n_error;
            r_pending   <= n_pending;
            r_held      <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret     <= n_ret;
        r_byte    <= n_byte;
        r_present <= n_present;
        r_eom     <= n_eom;
        r_det     <= n_det;
        r_inv     <= n_inv;
        r_cnt     <= n_cnt;
        r_idx     <= n_idx;
        r_x1      <= n_x1;
        r_x2      <= n_x2;
        r_y1      <= n_y1;
        r_mix_end <= n_mix_end;
        r_em0     <= n_em0;
        r_em1     <= n_em1;
        r_two     <= n_two;
    end

    // Active matrix: loaded before any read, so no reset
    always_ff @(posedge i_clk) begin
        if (mat_we_all) begin
            r_mat[0] <= i_key.key_a;
            r_mat[1] <= i_key.key_b;
            r_mat[2] <= i_key.key_c;
            r_mat[3] <= i_key.key_d;
        end else if (mat_we_one) begin
            r_mat[r_idx] <= i_mac_acc;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_byte      = r_byte;
        n_present   = r_present;
        n_eom       = r_eom;
        n_pending   = r_pending;
        n_pend_v    = r_pend_v;
        n_held      = r_held;
        n_held_v    = r_held_v;
        n_mat_ready = r_mat_ready;
        n_error     = r_error;
        n_det       = r_det;
        n_inv       = r_inv;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_x1        = r_x1;
        n_x2        = r_x2;
        n_y1        = r_y1;
        n_mix_end   = r_mix_end;
        n_em0       = r_em0;
        n_em1       = r_em1;
        n_two       = r_two;
        mat_we_all  = 1'b0;
        mat_we_one  = 1'b0;
        o_push      = 1'b0;
        o_result    = r_em0;
        o_mac_op    = '{keep: 1'b0, op_a: r_x1, op_b: r_x2};

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_byte    = i_data_byte;
                    n_present = i_byte_present;
                    n_eom     = i_end_of_message;
                    n_state   = r_mat_ready ? S_DATA : S_DET0;
                end
            end
            S_DET0: begin
                o_mac_op = '{keep: 1'b0, op_a: i_key.key_a, op_b: i_key.key_d};
                n_state  = S_DET1;
            end
            S_DET1: begin
                o_mac_op = '{keep: 1'b1, op_a: i_key.key_b, op_b: 8'd0 - i_key.key_c};
                n_state  = S_DETCHK;
            end
            S_DETCHK: begin
                n_mat_ready = 1'b1;
                n_det       = i_mac_acc;
                n_inv       = i_mac_acc;
                n_cnt       = 1'b0;
                if (!i_mac_acc[0]) begin
                    n_error = ST_BAD_KEY;
                    n_state = S_DATA;
                end else if (!i_key.decrypt) begin
                    mat_we_all = 1'b1;
                    n_state    = S_DATA;
                end else begin
                    n_state = S_INV_T;
                end
            end
            // Newton step: x <- x * (2 - det * x)
            S_INV_T: begin
                o_mac_op = '{keep: 1'b0, op_a: r_det, op_b: r_inv};
                n_state  = S_INV_X;
            end
            S_INV_X: begin
                o_mac_op = '{keep: 1'b0, op_a: r_inv, op_b: 8'd2 - i_mac_acc};
                n_state  = S_INV_U;
            end
            S_INV_U: begin
                n_inv = i_mac_acc;
                n_cnt = ~r_cnt;
                n_idx = 2'd0;
                n_state = (r_cnt == NewtonLast) ? S_MAT : S_INV_T;
            end
            S_MAT: begin
                o_mac_op = '{keep: 1'b0, op_a: r_inv, op_b: key_sel};
                n_state  = S_MATW;
            end
            S_MATW: begin
                mat_we_one = 1'b1;
                n_idx      = r_idx + 2'd1;
                n_state    = (r_idx == 2'd3) ? S_DATA : S_MAT;
            end
            S_DATA: begin
                n_state = S_END;
                if (r_error == ST_OK && r_present) begin
                    if (!r_pend_v) begin
                        n_pending = r_byte;
                        n_pend_v  = 1'b1;
                    end else begin
                        n_x1      = r_pending;
                        n_x2      = r_byte;
                        n_pend_v  = 1'b0;
                        n_mix_end = 1'b0;
                        n_state   = S_MIX0;
                    end
                end
            end
            S_MIX0: begin
                o_mac_op = '{keep: 1'b0, op_a: r_mat[0], op_b: r_x1};
                n_state  = S_MIX1;
            end
            S_MIX1: begin
                o_mac_op = '{keep: 1'b1, op_a: r_mat[1], op_b: r_x2};
                n_state  = S_MIX2;
            end
            S_MIX2: begin
                n_y1     = i_mac_acc;
                o_mac_op = '{keep: 1'b0, op_a: r_mat[2], op_b: r_x1};
                n_state  = S_MIX3;
            end
            S_MIX3: begin
                o_mac_op = '{keep: 1'b1, op_a: r_mat[3], op_b: r_x2};
                n_state  = S_MIXW;
            end
            S_MIXW: begin
                n_two = 1'b1;
                if (r_mix_end) begin
                    n_em0   = '{out_byte: r_y1, out_byte_valid: 1'b1, out_last: 1'b0,
                                status: ST_OK};
                    n_em1   = '{out_byte: i_mac_acc, out_byte_valid: 1'b1, out_last: 1'b1,
                                status: ST_OK};
                    n_ret   = S_DONE;
                    n_state = S_EM0;
                end else if (!i_key.decrypt) begin
                    n_em0   = '{out_byte: r_y1, out_byte_valid: 1'b1, out_last: 1'b0,
                                status: ST_OK};
                    n_em1   = '{out_byte: i_mac_acc, out_byte_valid: 1'b1, out_last: 1'b0,
                                status: ST_OK};
                    n_ret   = S_END;
                    n_state = S_EM0;
                end else begin
                    // Release the previous pair, hold this one for the pad check
                    n_held   = {r_y1, i_mac_acc};
                    n_held_v = 1'b1;
                    n_em0    = '{out_byte: held_hi, out_byte_valid: 1'b1, out_last: 1'b0,
                                 status: ST_OK};
                    n_em1    = '{out_byte: held_lo, out_byte_valid: 1'b1, out_last: 1'b0,
                                 status: ST_OK};
                    n_ret    = S_END;
                    n_state  = r_held_v ? S_EM0 : S_END;
                end
            end
            S_END: begin
                n_two = 1'b0;
                n_ret = S_DONE;
                if (!r_eom) begin
                    n_state = S_IDLE;
                end else if (r_error != ST_OK) begin
                    n_em0   = '{out_byte: '0, out_byte_valid: 1'b0, out_last: 1'b1,
                                status: r_error};
                    n_state = S_EM0;
                end else if (!i_key.decrypt) begin
                    n_x1      = r_pend_v ? r_pending : PadTwo;
                    n_x2      = r_pend_v ? PadOne : PadTwo;
                    n_mix_end = 1'b1;
                    n_state   = S_MIX0;
                end else if (r_pend_v || !r_held_v) begin
                    n_em0   = '{out_byte: '0, out_byte_valid: 1'b0, out_last: 1'b1,
                                status: ST_BAD_LEN};
                    n_state = S_EM0;
                end else if (held_lo == PadOne) begin
                    n_em0   = '{out_byte: held_hi, out_byte_valid: 1'b1, out_last: 1'b1,
                                status: ST_OK};
                    n_state = S_EM0;
                end else if (held_lo == PadTwo && held_hi == PadTwo) begin
                    n_em0   = '{out_byte: '0, out_byte_valid: 1'b0, out_last: 1'b1,
                                status: ST_OK};
                    n_state = S_EM0;
                end else begin
                    n_em0   = '{out_byte: '0, out_byte_valid: 1'b0, out_last: 1'b1,
                                status: ST_BAD_PAD};
                    n_state = S_EM0;
                end
            end
            S_EM0: begin
                o_result = r_em0;
                if (i_slot_free) begin
                    o_push  = 1'b1;
                    n_state = r_two ? S_EM1 : r_ret;
                end
            end
            S_EM1: begin
                o_result = r_em1;
                if (i_slot_free) begin
                    o_push  = 1'b1;
                    n_state = r_ret;
                end
            end
            S_DONE: begin
                n_pending   = '0;
                n_pend_v    = 1'b0;
                n_held      = '0;
                n_held_v    = 1'b0;
                n_mat_ready = 1'b0;
                n_error     = ST_OK;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Register write drops the message in progress
        if (i_clear) begin
            n_pending   = '0;
            n_pend_v    = 1'b0;
            n_held      = '0;
            n_held_v    = 1'b0;
            n_mat_ready = 1'b0;
            n_error     = ST_OK;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    a_mix_needs_good_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MIX0) |-> (r_mat_ready && r_error == ST_OK))
        else $error("pair mixed without a usable matrix");

    a_last_ends_message: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_result.out_last) |=> (r_state == S_DONE))
        else $error("final result did not close the message");

    a_status_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && !o_result.out_byte_valid) |-> o_result.out_last)
        else $error("status-only result that is not final");

    a_nonfinal_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && !o_result.out_last) |-> (o_result.status == ST_OK))
        else $error("error status on a non-final result");

endmodule

[src/hill_cipher_2x2_mod256_stream_core.sv]
// Top level of the 2x2 mod-256 Hill cipher byte stream core.
//
//   channel   direction  handshake                  payload
//   in        input      i_in_valid / o_in_stall    data_byte, byte_present, end_of_message
//   out       output     o_out_valid / i_out_stall  out_byte, out_byte_valid, out_last, status
//   cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// One 8x8 multiplier is shared; it sets the time per item. A byte that completes a pair
// takes 4 multiply-adds, then issues each byte as the output frees (in decrypt the pair
// is held back and the previous pair, if any, is issued); a byte that only opens a pair
// is stored. The first item of a message also computes the determinant, and in decrypt
// the inverse and the inverse matrix. The end item adds the pad pair in encrypt or the
// pad check in decrypt. Reset is synchronous and active low. The input is stalled while
// an item is in work; a stalled output only delays the next issue.
module hill_cipher_2x2_mod256_stream_core
    import hc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [ByteW-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [ByteW-1:0]   i_data_byte,
    input  logic               i_byte_present,
    input  logic               i_end_of_message,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [ByteW-1:0]   o_out_byte,
    output logic               o_out_byte_valid,
    output logic               o_out_last,
    output logic [1:0]         o_status
);

    t_key    r_key, n_key;
    logic    cfg_hit;
    t_result r_out;
    logic    r_out_valid;
    logic    slot_free;
    logic    push;
    t_result result;
    t_mac_op mac_op;
    t_byte   mac_acc;
    logic    busy;

    always_comb begin
        n_key   = r_key;
        cfg_hit = 1'b0;
        if (i_cfg_we) begin
            cfg_hit = 1'b1;
            case (t_reg_idx'(i_cfg_index))
                REG_KEY_A:   n_key.key_a   = i_cfg_data;
                REG_KEY_B:   n_key.key_b   = i_cfg_data;
                REG_KEY_C:   n_key.key_c   = i_cfg_data;
                REG_KEY_D:   n_key.key_d   = i_cfg_data;
                REG_DECRYPT: n_key.decrypt = i_cfg_data[0];
                default:     cfg_hit       = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '{key_a: 8'd1, key_b: 8'd0, key_c: 8'd0, key_d: 8'd1, decrypt: 1'b0};
        end else begin
            r_key <= n_key;
        end
    end

    hc_mac u_mac (
        .i_clk (i_clk),
        .i_op  (mac_op),
        .o_acc (mac_acc)
    );

    hc_seq u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_key            (r_key),
        .i_clear          (cfg_hit),
        .i_in_valid       (i_in_valid),
        .i_data_byte      (i_data_byte),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .o_busy           (busy),
        .i_slot_free      (slot_free),
        .o_push           (push),
        .o_result         (result),
        .o_mac_op         (mac_op),
        .i_mac_acc        (mac_acc)
    );

    // Output register: refill when empty or when the current result transfers
    assign slot_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= result;
        end
    end

    assign o_in_stall       = busy;
    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out.out_byte;
    assign o_out_byte_valid = r_out.out_byte_valid;
    assign o_out_last       = r_out.out_last;
    assign o_status         = r_out.status;

endmodule
